// ===== rtl/core/ps2mpd_pkg.sv =====
// types, constants and decode helpers for the ps2 mouse packet decoder
package ps2mpd_pkg;

	localparam int IDLE_BITS    = 24;
	localparam int TIMEOUT_BITS = 24;
	localparam int CMP_BITS     = (IDLE_BITS > TIMEOUT_BITS) ? IDLE_BITS : TIMEOUT_BITS;
	localparam int CFG_DATA_W   = 24;
	localparam int CFG_INDEX_W  = 2;
	localparam int IN_DATA_W    = 8;
	localparam int OUT_DATA_W   = 32;

	localparam logic [IDLE_BITS-1:0]    IDLE_MAX        = '1;
	localparam logic [2:0]              LEN_RESET       = 3'd3;
	localparam logic [2:0]              LEN_MAX         = 3'd4;
	localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET   = TIMEOUT_BITS'(500000);

	// item kinds on tuser
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_PACKET_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FIVE_BUTTONS  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

	typedef struct packed {
		logic [4:0]        buttons;
		logic signed [3:0] wheel;
		logic signed [8:0] dy;
		logic signed [8:0] dx;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

	function automatic logic [OUT_DATA_W-1:0] pack_result(input result_t r);
		pack_result = {{(OUT_DATA_W - RESULT_W){1'b0}}, r};
	endfunction

endpackage

// ===== rtl/core/ps2_mouse_packet_decoder.sv =====
// ps2 mouse packet decoder: byte framing, idle timeout and packet decode
//
// channel | dir | payload
// s       | in  | tdata: data_byte[7:0]; tuser: req_type
// m       | out | tdata: dx[8:0], dy[17:9], wheel[21:18], buttons[26:22], zero fill
// cfg     | in  | cfg_index selects packet_length, five_buttons, timeout_ticks
//
// one item per cycle unless the skid stage is full; finished packets are registered
// the result register plus a one-entry skid stage decouple s_tready from m_tready
// reset clears the byte count, idle count and both result stages
// stalls on m back up to s only once the skid stage is full
module ps2_mouse_packet_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ps2mpd_pkg::IN_DATA_W-1:0] s_tdata,   // data_byte[7:0]
	input  logic                             s_tuser,   // req_type
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ps2mpd_pkg::OUT_DATA_W-1:0] m_tdata,  // dx, dy, wheel, buttons, zeros
	input  logic                             cfg_we,
	input  logic [ps2mpd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ps2mpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ps2mpd_pkg::*;

	logic [2:0]              packet_length_q;
	logic                    five_buttons_q;
	logic [TIMEOUT_BITS-1:0] timeout_ticks_q;

	logic [7:0]           packet_bytes_q [4];
	logic [2:0]           byte_count_q;
	logic [IDLE_BITS-1:0] idle_count_q;

	logic    out_valid_q;
	result_t out_data_q;
	logic    skid_valid_q;
	result_t skid_data_q;

	logic           accept;
	logic           is_byte;
	logic [2:0]     len;
	logic           timed_out;
	logic [2:0]     bc_start;
	logic [2:0]     pos;
	logic [2:0]     next_count;
	logic           finish;
	logic [7:0]     b [4];
	result_t        res;
	logic           res_valid;
	logic           out_take;

	assign accept  = s_tvalid && s_tready;
	assign is_byte = (s_tuser == REQ_BYTE);
	assign len     = (packet_length_q > LEN_MAX) ? LEN_MAX : packet_length_q;

	always_comb begin
		timed_out  = CMP_BITS'(idle_count_q) > CMP_BITS'(timeout_ticks_q);
		bc_start   = timed_out ? 3'd0 : byte_count_q;
		pos        = (bc_start >= len) ? 3'd0 : bc_start;
		next_count = pos + 3'd1;
		finish     = (len != 3'd0) && (next_count == len);
		for (int i = 0; i < 4; i++) begin
			b[i] = (pos[1:0] == 2'(i)) ? s_tdata : packet_bytes_q[i];
		end
		res.dy      = {b[0][5], ((len > 3'd2) ? b[2] : 8'd0)};
		res.dx      = {b[0][4], ((len > 3'd1) ? b[1] : 8'd0)};
		res.wheel   = (len == LEN_MAX) ? b[3][3:0] : 4'd0;
		res.buttons = {((len == LEN_MAX && five_buttons_q) ? b[3][5:4] : 2'b00), b[0][2:0]};
	end

	assign res_valid = accept && is_byte && finish;
	assign out_take  = out_valid_q && m_tready;
	assign s_tready  = !skid_valid_q;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = pack_result(out_data_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_length_q <= LEN_RESET;
			five_buttons_q  <= 1'b0;
			timeout_ticks_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PACKET_LENGTH: packet_length_q <= cfg_data[2:0];
				CFG_FIVE_BUTTONS:  five_buttons_q  <= cfg_data[0];
				CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data[TIMEOUT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= 3'd0;
			idle_count_q <= '0;
		end else if (accept) begin
			if (!is_byte) begin
				if (idle_count_q != IDLE_MAX) begin
					idle_count_q <= idle_count_q + 1'b1;
				end
			end else begin
				idle_count_q <= '0;
				if (len == 3'd0) begin
					byte_count_q <= bc_start;
				end else if (finish) begin
					byte_count_q <= 3'd0;
				end else begin
					byte_count_q <= next_count;
				end
			end
		end
	end

	// packet byte store
	always_ff @(posedge clk) begin
		if (accept && is_byte && len != 3'd0) begin
			packet_bytes_q[pos[1:0]] <= s_tdata;
		end
	end

	// result register and skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || out_take) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= res_valid;
				end
			end else if (res_valid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_take) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (res_valid) begin
				out_data_q <= res;
			end
		end else if (res_valid) begin
			skid_data_q <= res;
		end
	end

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage full while result register empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= LEN_MAX)
		else $error("byte count beyond packet size");

	a_result_from_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (len != 3'd0 && next_count == len))
		else $error("result without a finished packet");

	a_tick_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_byte && idle_count_q != IDLE_MAX)
		|=> idle_count_q == $past(idle_count_q) + 1'b1)
		else $error("tick item did not advance idle count");

	a_byte_clears_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_byte) |=> idle_count_q == '0)
		else $error("byte item did not clear idle count");
`endif

endmodule
